FILE: hdl/bb3_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_FRAME_WIDTH  = 640;
  localparam int DEF_FRAME_HEIGHT = 480;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Nine 8-bit channel values sum to at most 2295.
  localparam int SUM_W = 12;

  // Truncating divide by 9 as (s * 7282) >> 16, exact for s up to 2295.
  localparam int               DIV9_RECIP_W = 13;
  localparam logic [12:0]      DIV9_RECIP   = 13'd7282;
  localparam int               DIV9_SHIFT   = 16;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

  typedef logic [23:0] rgb_t;

  // One line store entry: the two lines above the one being written.
  typedef struct packed {
    rgb_t upper;
    rgb_t lower;
  } line_pair_t;

  // One window column, row0 on top.
  typedef struct packed {
    rgb_t row0;
    rgb_t row1;
    rgb_t row2;
  } wnd_col_t;

  // Which window rows and columns lie inside the frame.
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } tap_mask_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } chan_sum_t;

endpackage

FILE: hdl/bb3_line_store.sv
// Two-line store with registered read and write-to-read forwarding.
`timescale 1ns / 1ps

module bb3_line_store #(
  parameter int DEPTH = bb3_pkg::DEF_MAX_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  bb3_pkg::line_pair_t  wr_data,
  output bb3_pkg::line_pair_t  rd_data
);

  bb3_pkg::rgb_t       upper_mem [DEPTH];
  bb3_pkg::rgb_t       lower_mem [DEPTH];
  bb3_pkg::line_pair_t mem_q_r;
  logic [AW-1:0]       rd_addr_r;
  logic [AW-1:0]       lw_addr_r;
  bb3_pkg::line_pair_t lw_data_r;
  logic                lw_valid_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r.upper <= upper_mem[rd_addr];
      mem_q_r.lower <= lower_mem[rd_addr];
      rd_addr_r     <= rd_addr;
    end
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_data.upper;
      lower_mem[wr_addr] <= wr_data.lower;
      lw_addr_r          <= wr_addr;
      lw_data_r          <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  // The newest write may land on the same edge as the read of that entry
  // (a one-pixel line), so the read returns it from the last-write register.
  // It is always the most recent data for its entry, so the bypass is safe
  // even when the array already held it.
  assign rd_data = (lw_valid_r && (lw_addr_r == rd_addr_r)) ? lw_data_r : mem_q_r;

endmodule

FILE: hdl/bb3_window.sv
// 3x3 window registers with frame-edge masking and per-channel sums.
`timescale 1ns / 1ps

module bb3_window (
  input  logic                clk,
  input  logic                shift_en,
  input  bb3_pkg::wnd_col_t   new_col,
  input  bb3_pkg::tap_mask_t  mask,
  output bb3_pkg::chan_sum_t  sums
);

  bb3_pkg::wnd_col_t col_r [3];
  bb3_pkg::rgb_t     tap   [9];
  logic [2:0]        col_on;
  logic [2:0]        row_on;
  logic [bb3_pkg::SUM_W-1:0] red_sum;
  logic [bb3_pkg::SUM_W-1:0] green_sum;
  logic [bb3_pkg::SUM_W-1:0] blue_sum;

  // Column 2 is the newest, column 0 the oldest.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r[0] <= col_r[1];
      col_r[1] <= col_r[2];
      col_r[2] <= new_col;
    end
  end

  assign col_on = {mask.right, 1'b1, mask.left};
  assign row_on = {mask.bot, 1'b1, mask.top};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tap[3*c]   = (row_on[0] && col_on[c]) ? col_r[c].row0 : '0;
      tap[3*c+1] = (row_on[1] && col_on[c]) ? col_r[c].row1 : '0;
      tap[3*c+2] = (row_on[2] && col_on[c]) ? col_r[c].row2 : '0;
    end
  end

  always_comb begin
    red_sum   = '0;
    green_sum = '0;
    blue_sum  = '0;
    for (int i = 0; i < 9; i++) begin
      red_sum   = red_sum   + bb3_pkg::SUM_W'(tap[i][23:16]);
      green_sum = green_sum + bb3_pkg::SUM_W'(tap[i][15:8]);
      blue_sum  = blue_sum  + bb3_pkg::SUM_W'(tap[i][7:0]);
    end
  end

  assign sums.red   = red_sum;
  assign sums.green = green_sum;
  assign sums.blue  = blue_sum;

endmodule

FILE: hdl/bb3_pack.sv
// Divides the three channel sums by nine and packs the output pixel.
`timescale 1ns / 1ps

module bb3_pack (
  input  bb3_pkg::chan_sum_t sums,
  output logic [31:0]        pixel
);

  localparam int PW = bb3_pkg::SUM_W + bb3_pkg::DIV9_RECIP_W;

  logic [PW-1:0] red_prod;
  logic [PW-1:0] green_prod;
  logic [PW-1:0] blue_prod;

  assign red_prod   = PW'(sums.red)   * PW'(bb3_pkg::DIV9_RECIP);
  assign green_prod = PW'(sums.green) * PW'(bb3_pkg::DIV9_RECIP);
  assign blue_prod  = PW'(sums.blue)  * PW'(bb3_pkg::DIV9_RECIP);

  assign pixel = {red_prod[bb3_pkg::DIV9_SHIFT +: 8],
                  green_prod[bb3_pkg::DIV9_SHIFT +: 8],
                  blue_prod[bb3_pkg::DIV9_SHIFT +: 8],
                  bb3_pkg::ALPHA_OPAQUE};

endmodule

FILE: hdl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur with a two-line store.
// Throughput: one item per cycle unless stalled, set by the single read and single write
// per cycle on the line store. A result is the blur of the pixel that lies frame_width + 1
// items back; it passes s1, s2, s3 and the output register once its last item is taken.
// Reset: frame counters cleared, width 640, height 480 (clamped), pipeline empty; the line
// store is not cleared, as only lines written in the current frame are ever read unmasked.
`timescale 1ns / 1ps

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [31:0]                    in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_pixel,
  output logic                           out_frame_last
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int YW  = $clog2(MAX_HEIGHT + 2);
  localparam int CWW = (WW > bb3_pkg::CFG_DATA_W) ? WW : bb3_pkg::CFG_DATA_W;
  localparam int CHW = (HW > bb3_pkg::CFG_DATA_W) ? HW : bb3_pkg::CFG_DATA_W;
  localparam int RST_W = (bb3_pkg::DEF_FRAME_WIDTH > MAX_WIDTH) ?
                         MAX_WIDTH : bb3_pkg::DEF_FRAME_WIDTH;
  localparam int RST_H = (bb3_pkg::DEF_FRAME_HEIGHT > MAX_HEIGHT) ?
                         MAX_HEIGHT : bb3_pkg::DEF_FRAME_HEIGHT;

  // Frame size, already clamped.
  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [CWW-1:0] cfg_ext_w;
  logic [CHW-1:0] cfg_ext_h;
  logic [WW-1:0]  w_wr;
  logic [HW-1:0]  h_wr;

  // Frame position counters.
  logic [XW-1:0] in_col_r, in_col_nxt;
  logic [YW-1:0] in_row_r, in_row_nxt;
  logic [XW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  // Item decode at the input.
  logic               tail;
  logic               drop;
  logic               take;
  logic               emit;
  logic               in_col_end;
  logic               out_col_end;
  logic               out_row_end;
  logic               is_last;
  bb3_pkg::tap_mask_t mask0;

  // Pipeline flow.
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_go, s2_go, s3_go;

  logic               s1_valid_r;
  logic               s1_tail_r;
  logic               s1_emit_r;
  logic               s1_last_r;
  bb3_pkg::tap_mask_t s1_mask_r;
  bb3_pkg::rgb_t      s1_rgb_r;
  logic [XW-1:0]      s1_addr_r;

  logic               s2_valid_r;
  logic               s2_last_r;
  bb3_pkg::tap_mask_t s2_mask_r;

  logic               s3_valid_r;
  logic               s3_last_r;
  bb3_pkg::chan_sum_t s3_sum_r;

  logic               out_valid_r;
  logic [31:0]        out_pixel_r;
  logic               out_last_r;

  bb3_pkg::line_pair_t rd_data;
  bb3_pkg::line_pair_t wr_data;
  bb3_pkg::wnd_col_t   new_col;
  bb3_pkg::chan_sum_t  win_sums;
  logic [31:0]         packed_pixel;

  // Register writes, clamped to 1..MAX.
  always_comb begin
    cfg_ext_w = CWW'(cfg_wdata);
    cfg_ext_h = CHW'(cfg_wdata);
    if (cfg_wdata == '0) begin
      w_wr = WW'(1);
    end else if (cfg_ext_w > CWW'(MAX_WIDTH)) begin
      w_wr = WW'(MAX_WIDTH);
    end else begin
      w_wr = WW'(cfg_ext_w);
    end
    if (cfg_wdata == '0) begin
      h_wr = HW'(1);
    end else if (cfg_ext_h > CHW'(MAX_HEIGHT)) begin
      h_wr = HW'(MAX_HEIGHT);
    end else begin
      h_wr = HW'(cfg_ext_h);
    end
  end

  // Input decode. A drain item inside the frame has no effect at all.
  assign tail        = in_row_r >= YW'(h_r);
  assign drop        = in_op && !tail;
  assign take        = in_valid && !in_stall && !drop;
  assign emit        = (in_row_r > YW'(1)) || ((in_row_r == YW'(1)) && (in_col_r != '0));
  assign in_col_end  = (WW'(in_col_r) + WW'(1)) == w_r;
  assign out_col_end = (WW'(out_col_r) + WW'(1)) == w_r;
  assign out_row_end = (out_row_r + HW'(1)) == h_r;
  assign is_last     = emit && out_row_end && out_col_end;

  assign mask0.top   = out_row_r != '0;
  assign mask0.bot   = !out_row_end;
  assign mask0.left  = out_col_r != '0;
  assign mask0.right = !out_col_end;

  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH:  w_nxt = w_wr;
        bb3_pkg::CFG_FRAME_HEIGHT: h_nxt = h_wr;
        default: ;
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (is_last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (emit) begin
          if (out_col_end) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + HW'(1);
          end else begin
            out_col_nxt = out_col_r + XW'(1);
          end
        end
        if (in_col_end) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + YW'(1);
        end else begin
          in_col_nxt = in_col_r + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WW'(RST_W);
      h_r       <= HW'(RST_H);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Each stage moves when the one after it is empty or moving.
  assign out_free = !out_valid_r || !out_stall;
  assign s3_free  = !s3_valid_r || out_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign s2_go    = s2_valid_r && s3_free;
  assign s3_go    = s3_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= take;
      end
      if (s2_free) begin
        s2_valid_r <= s1_go && s1_emit_r;
      end
      if (s3_free) begin
        s3_valid_r <= s2_go;
      end
      if (out_free) begin
        out_valid_r <= s3_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_tail_r <= tail;
      s1_emit_r <= emit;
      s1_last_r <= is_last;
      s1_mask_r <= mask0;
      s1_rgb_r  <= in_pixel[31:8];
      s1_addr_r <= in_col_r;
    end
    if (s1_go) begin
      s2_last_r <= s1_last_r;
      s2_mask_r <= s1_mask_r;
    end
    if (s2_go) begin
      s3_last_r <= s2_last_r;
      s3_sum_r  <= win_sums;
    end
    if (s3_go) begin
      out_pixel_r <= packed_pixel;
      out_last_r  <= s3_last_r;
    end
  end

  // The entry for a column moves down one line as the new pixel goes in.
  // Items after the last line only read.
  assign wr_data.upper = rd_data.lower;
  assign wr_data.lower = s1_rgb_r;

  assign new_col.row0 = rd_data.upper;
  assign new_col.row1 = rd_data.lower;
  assign new_col.row2 = s1_rgb_r;

  bb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .wr_en   (s1_go && !s1_tail_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  bb3_window u_window (
    .clk      (clk),
    .shift_en (s1_go),
    .new_col  (new_col),
    .mask     (s2_mask_r),
    .sums     (win_sums)
  );

  bb3_pack u_pack (
    .sums  (s3_sum_r),
    .pixel (packed_pixel)
  );

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_frame_last = out_last_r;

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_last) |=> (in_col_r == '0 && in_row_r == '0 &&
                           out_col_r == '0 && out_row_r == '0))
    else $error("counters not restarted after the last item of a frame");

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < w_r)
    else $error("input column beyond frame width");

  a_out_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r < h_r)
    else $error("output row beyond frame height");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(s1_rgb_r)))
    else $error("first stage item lost while blocked");

endmodule
